/* sv/imabd_pkg.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder package
// Shared widths, register indexes and the structures passed between the
// sequencer, the decode core and the channel state memory.
// ----------------------------------------------------------------------------
`default_nettype none

package imabd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_PER_BLOCK = 1'b1;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 7;
    localparam int FRAME_W  = 7;
    localparam int CHAN_W   = 3;
    // Internal channel number, wide enough for the largest channel count.
    localparam int CH_W     = 4;

    localparam logic [IDX_W-1:0] STEP_MAX = 7'd88;

    // Per-channel decoder state as held in memory.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pred;
        logic [IDX_W-1:0]           idx;
    } chan_state_t;

    // One accepted word together with its place in the block.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [CH_W-1:0]    ch;
        logic               hdr;
        logic               last_chunk;
        logic               last_blk;
        logic [FRAME_W-1:0] frame_base;
    } job_t;

endpackage

`default_nettype wire

/* sv/ima_adpcm_block_decoder_top.sv */
// An accepted word is held in the job register and each decoded sample in the
// result register. A code word yields eight samples (seven in the last chunk
// of a block), one nibble per cycle through the shared predictor unless the
// result is stalled, which holds the decode in place; a header gives one sample.
// Reset clears the block position and restores one channel and eight chunks
// per block; channel state in memory is undefined until a header writes it.
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder, top level
// Multichannel block-framed 4-bit IMA ADPCM decoder with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_block_decoder_top #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_CHUNKS   = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [imabd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [imabd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [imabd_pkg::WORD_W-1:0]          stream_word,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [imabd_pkg::SAMPLE_W-1:0]      audio_sample,
    output logic [imabd_pkg::CHAN_W-1:0]               channel,
    output logic [imabd_pkg::FRAME_W-1:0]              frame_index,
    output logic                                       last_of_word,
    output logic                                       end_of_block
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    imabd_pkg::job_t        job;
    logic                   take;
    logic                   ram_we;
    logic [imabd_pkg::CH_W-1:0] ram_ch;
    logic [imabd_pkg::CH_W-1:0] ram_wch;
    imabd_pkg::chan_state_t ram_wdata;
    imabd_pkg::chan_state_t ram_rdata;

    // Block position and configuration.
    imabd_seq #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_CHUNKS   (MAX_CHUNKS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stream_word (stream_word),
        .take        (take),
        .job         (job)
    );

    // Per-channel predictor and step index.
    imabd_ram #(
        .WIDTH ($bits(imabd_pkg::chan_state_t)),
        .DEPTH (MAX_CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wch[AW-1:0]),
        .wdata (ram_wdata),
        .re    (take),
        .raddr (ram_ch[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Nibble decoder and result register.
    imabd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .job_in       (job),
        .take         (take),
        .ram_we       (ram_we),
        .ram_ch       (ram_ch),
        .ram_wch      (ram_wch),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .audio_sample (audio_sample),
        .channel      (channel),
        .frame_index  (frame_index),
        .last_of_word (last_of_word),
        .end_of_block (end_of_block)
    );

endmodule

`default_nettype wire

/* sv/imabd_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module imabd_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/imabd_seq.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM block sequencer
// Holds the configuration registers and the block position, and describes
// each incoming word: its channel, whether it is a header, and its frames.
// ----------------------------------------------------------------------------
`default_nettype none

module imabd_seq #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_CHUNKS   = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [imabd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [imabd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [imabd_pkg::WORD_W-1:0]         stream_word,
    input  wire logic                                 take,
    output imabd_pkg::job_t                           job
);

    localparam int CPW = $clog2(MAX_CHUNKS + 1);

    logic [3:0]                   cc_reg;
    logic [4:0]                   cpb_reg;
    logic [CPW-1:0]               cp_reg, cp_next;
    logic [imabd_pkg::CH_W-1:0]   ch_reg, ch_next;
    logic [4:0]                   nc;
    logic [6:0]                   nk;
    logic                         last_ch;
    logic                         last_chunk;
    logic                         hdr;
    logic [CPW+2:0]               cp_x8;

    // Effective counts, with out-of-range settings held to the legal range.
    always_comb
    begin
        if (cc_reg == 4'd0)
            nc = 5'd1;
        else if ({1'b0, cc_reg} > 5'(MAX_CHANNELS))
            nc = 5'(MAX_CHANNELS);
        else
            nc = {1'b0, cc_reg};

        if (cpb_reg == 5'd0)
            nk = 7'd1;
        else if ({2'b00, cpb_reg} > 7'(MAX_CHUNKS))
            nk = 7'(MAX_CHUNKS);
        else
            nk = {2'b00, cpb_reg};
    end

    assign hdr        = (cp_reg == '0);
    assign last_ch    = (({1'b0, ch_reg} + 5'd1) >= nc);
    assign last_chunk = (7'(cp_reg) >= nk);
    assign cp_x8      = {cp_reg - CPW'(1), 3'b000};

    // Description of the word now offered.
    always_comb
    begin
        job.word       = stream_word;
        job.ch         = ch_reg;
        job.hdr        = hdr;
        job.last_chunk = last_chunk;
        job.last_blk   = last_chunk && last_ch;
        job.frame_base = 7'(cp_x8) | 7'd1;
    end

    // Block position after the word is taken.
    always_comb
    begin
        cp_next = cp_reg;
        ch_next = ch_reg;
        if (take)
        begin
            if (!last_ch)
            begin
                ch_next = ch_reg + imabd_pkg::CH_W'(1);
            end
            else
            begin
                ch_next = '0;
                if (hdr)
                    cp_next = CPW'(1);
                else if (last_chunk)
                    cp_next = '0;
                else
                    cp_next = cp_reg + CPW'(1);
            end
        end
    end

    // Configuration and position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg  <= 4'd1;
            cpb_reg <= 5'd8;
            cp_reg  <= '0;
            ch_reg  <= '0;
        end
        else
        begin
            cp_reg <= cp_next;
            ch_reg <= ch_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    imabd_pkg::REG_NUM_CHANNELS:     cc_reg  <= cfg_data[3:0];
                    imabd_pkg::REG_CHUNKS_PER_BLOCK: cpb_reg <= cfg_data;
                    default:                         ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* sv/imabd_core.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM decode core
// Holds one word at a time, decodes one nibble a cycle (unless the result is
// stalled) against memory state, writes it back and drives the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module imabd_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire imabd_pkg::job_t                       job_in,
    output logic                                       take,
    output logic                                       ram_we,
    output logic [imabd_pkg::CH_W-1:0]                 ram_ch,
    output logic [imabd_pkg::CH_W-1:0]                 ram_wch,
    output imabd_pkg::chan_state_t                     ram_wdata,
    input  wire imabd_pkg::chan_state_t                ram_rdata,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [imabd_pkg::SAMPLE_W-1:0]      audio_sample,
    output logic [imabd_pkg::CHAN_W-1:0]               channel,
    output logic [imabd_pkg::FRAME_W-1:0]              frame_index,
    output logic                                       last_of_word,
    output logic                                       end_of_block
);

    localparam logic [14:0] STEP_TAB [89] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16,
        15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37,
        15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88,
        15'd97, 15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190,
        15'd209, 15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408,
        15'd449, 15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876,
        15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707,
        15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327,
        15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    imabd_pkg::job_t        job_reg;
    logic                   job_valid_reg, job_valid_next;
    logic [2:0]             nib_reg;
    logic                   first_reg;
    logic                   fwd_reg;
    imabd_pkg::chan_state_t work_reg;

    logic                                  out_valid_reg;
    logic signed [imabd_pkg::SAMPLE_W-1:0] pcm_reg;
    logic [imabd_pkg::CHAN_W-1:0]          chan_reg;
    logic [imabd_pkg::FRAME_W-1:0]         frame_reg;
    logic                                  low_reg;
    logic                                  eob_reg;

    imabd_pkg::chan_state_t src;
    imabd_pkg::chan_state_t dec_state;
    imabd_pkg::chan_state_t hdr_state;
    imabd_pkg::chan_state_t res;
    logic [3:0]             code;
    logic [14:0]            step;
    logic [16:0]            diff;
    logic signed [17:0]     sum;
    logic signed [7:0]      adj;
    logic signed [7:0]      idx_sum;
    logic [7:0]             hdr_byte;
    logic [2:0]             nib_last;
    logic                   is_last;
    logic                   advance;
    logic                   finish;

    // State source: memory on the first cycle of a word, unless the previous
    // word wrote the same channel at the read edge; the working copy after.
    assign src = (first_reg && !fwd_reg) ? ram_rdata : work_reg;

    // One nibble through the predictor.
    always_comb
    begin
        code = job_reg.word[{nib_reg, 2'b00} +: 4];
        step = (src.idx > imabd_pkg::STEP_MAX) ? 15'd32767 : STEP_TAB[src.idx];
        diff = 17'(step >> 3);
        if (code[2])
            diff = diff + 17'(step);
        if (code[1])
            diff = diff + 17'(step >> 1);
        if (code[0])
            diff = diff + 17'(step >> 2);
        if (code[3])
            sum = 18'(src.pred) - 18'(signed'({1'b0, diff}));
        else
            sum = 18'(src.pred) + 18'(signed'({1'b0, diff}));

        // Saturate to the signed 16-bit range.
        if (sum > 18'sd32767)
            dec_state.pred = 16'sh7FFF;
        else if (sum < -18'sd32768)
            dec_state.pred = 16'sh8000;
        else
            dec_state.pred = sum[15:0];

        // Step index adjustment, held to the table range.
        adj = code[2] ? 8'sd2 + signed'({5'b00000, code[1:0], 1'b0}) : -8'sd1;
        idx_sum = signed'({1'b0, src.idx}) + adj;
        if (idx_sum < 8'sd0)
            dec_state.idx = '0;
        else if (idx_sum > 8'(imabd_pkg::STEP_MAX))
            dec_state.idx = imabd_pkg::STEP_MAX;
        else
            dec_state.idx = idx_sum[6:0];
    end

    // Header word: initial sample and a signed step index byte.
    always_comb
    begin
        hdr_byte       = job_reg.word[23:16];
        hdr_state.pred = job_reg.word[15:0];
        if (hdr_byte[7])
            hdr_state.idx = '0;
        else if (hdr_byte[6:0] > imabd_pkg::STEP_MAX)
            hdr_state.idx = imabd_pkg::STEP_MAX;
        else
            hdr_state.idx = hdr_byte[6:0];
    end

    assign res = job_reg.hdr ? hdr_state : dec_state;

    // Progress control.
    assign nib_last = job_reg.last_chunk ? 3'd6 : 3'd7;
    assign is_last  = job_reg.hdr || (nib_reg == nib_last);
    assign advance  = job_valid_reg && (!out_valid_reg || !out_stall);
    assign finish   = advance && is_last;
    assign take     = in_valid && (!job_valid_reg || finish);
    assign in_stall = job_valid_reg && !finish;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (take)
            job_valid_next = 1'b1;
        else if (finish)
            job_valid_next = 1'b0;
    end

    // Memory access: read the new word's channel at acceptance, write the
    // current word's channel back on its last nibble.
    assign ram_ch    = job_in.ch;
    assign ram_wch   = job_reg.ch;
    assign ram_we    = finish;
    assign ram_wdata = res;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            fwd_reg       <= 1'b0;
            nib_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= job_valid_reg;
            if (take)
            begin
                first_reg <= 1'b1;
                fwd_reg   <= finish && (job_reg.ch == job_in.ch);
                nib_reg   <= '0;
            end
            else
            begin
                if (job_valid_reg)
                    first_reg <= 1'b0;
                if (advance)
                    nib_reg <= nib_reg + 3'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_in;
        if (advance)
            work_reg <= res;
        else if (first_reg)
            work_reg <= src;
        if (advance)
        begin
            pcm_reg   <= res.pred;
            chan_reg  <= imabd_pkg::CHAN_W'(job_reg.ch);
            frame_reg <= job_reg.hdr ? '0 : job_reg.frame_base + 7'(nib_reg);
            low_reg   <= is_last;
            eob_reg   <= !job_reg.hdr && is_last && job_reg.last_blk;
        end
    end

    assign out_valid    = out_valid_reg;
    assign audio_sample = pcm_reg;
    assign channel      = chan_reg;
    assign frame_index  = frame_reg;
    assign last_of_word = low_reg;
    assign end_of_block = eob_reg;

endmodule

`default_nettype wire

/* sv/imabd_checker.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imabd_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic signed [imabd_pkg::SAMPLE_W-1:0] audio_sample,
    input wire logic [imabd_pkg::CHAN_W-1:0]          channel,
    input wire logic [imabd_pkg::FRAME_W-1:0]         frame_index,
    input wire logic                                  last_of_word,
    input wire logic                                  end_of_block
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(audio_sample)
            && $stable(channel) && $stable(frame_index)
            && $stable(last_of_word) && $stable(end_of_block))
        else $error("stalled result changed");

    // The end of a block is always the last sample of its word.
    a_eob_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_block |-> last_of_word && frame_index != '0)
        else $error("end of block not on the last sample of a code word");

    // A header yields exactly one sample.
    a_hdr_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_index == '0 |-> last_of_word && !end_of_block)
        else $error("header sample not marked as last of word");

    // A code word ends on its eighth nibble, or its seventh in a last chunk.
    a_word_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_word && frame_index != '0
            |-> frame_index[2:0] == 3'd0 || frame_index[2:0] == 3'd7)
        else $error("code word ended at an unexpected nibble");

endmodule

bind ima_adpcm_block_decoder_top imabd_checker u_imabd_checker (.*);

`default_nettype wire
